>>> hw/rtl/sdat_pkg.sv
// shared types, codes and defaults for the sorted day aggregate table
// no dependencies; used by the register write interface, the top level and the checker
package sdat_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 256;

    localparam logic [31:0] MIN_DAY_RST     = 32'd18262;
    localparam logic [31:0] MAX_DAY_RST     = 32'd47481;
    localparam logic [15:0] MAX_MINUTES_RST = 16'd1440;
    localparam logic [15:0] SAT16           = 16'hFFFF;

    localparam int unsigned CFG_IDX_W = 3;

    typedef enum logic [2:0] {
        CFG_MIN_DAY       = 3'd0,
        CFG_MAX_DAY       = 3'd1,
        CFG_MAX_MINUTES   = 3'd2,
        CFG_FILTER_ENABLE = 3'd3,
        CFG_FILTER_HASH   = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_MERGED      = 3'd0,
        ST_INSERTED    = 3'd1,
        ST_IMPLAUSIBLE = 3'd2,
        ST_FILTERED    = 3'd3,
        ST_FULL        = 3'd4,
        ST_BADINDEX    = 3'd5,
        ST_CLEARED     = 3'd6
    } status_t;

    typedef struct packed {
        logic [31:0] day;
        logic [15:0] minutes;
        logic [15:0] pages;
        logic [15:0] sessions;
    } entry_t;

    typedef struct packed {
        logic [2:0]  status;
        entry_t      entry;
        logic [8:0]  count;
    } result_t;

    function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? SAT16 : s[15:0];
    endfunction

endpackage

>>> hw/rtl/sdat_req_if.sv
// request channel of the sorted day aggregate table: one table operation
// depends on nothing
interface sdat_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [31:0] rec_day;
    logic [15:0] rec_minutes;
    logic [15:0] rec_pages;
    logic [31:0] rec_hash;
    logic [7:0]  read_index;

    modport source (output valid, op, rec_day, rec_minutes, rec_pages, rec_hash, read_index,
                    input ready);
    modport sink (input valid, op, rec_day, rec_minutes, rec_pages, rec_hash, read_index,
                  output ready);
endinterface

>>> hw/rtl/sdat_rsp_if.sv
// result channel of the sorted day aggregate table
// depends on nothing
interface sdat_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] entry_day;
    logic [15:0] entry_minutes;
    logic [15:0] entry_pages;
    logic [15:0] entry_sessions;
    logic [8:0]  entry_count;

    modport source (output valid, status, entry_day, entry_minutes, entry_pages,
                    entry_sessions, entry_count, input ready);
    modport sink (input valid, status, entry_day, entry_minutes, entry_pages,
                  entry_sessions, entry_count, output ready);
endinterface

>>> hw/rtl/sdat_cfg_if.sv
// register write channel of the sorted day aggregate table
// depends on sdat_pkg for the index width
interface sdat_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [sdat_pkg::CFG_IDX_W-1:0]   index;
    logic [31:0]                      data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/sorted_day_aggregate_table_top.sv
// sorted day aggregate table: entry memory, sequencer and register file
// depends on sdat_pkg, sdat_req_if, sdat_rsp_if, sdat_cfg_if
//
//  channel  dir  handshake    payload
//  req      in   valid/ready  op, rec_day, rec_minutes, rec_pages, rec_hash, read_index
//  rsp      out  valid/ready  status, entry_day, entry_minutes, entry_pages,
//                             entry_sessions, entry_count
//  cfg      in   valid/ready  index, data (ready always high)
//
// one request at a time; req.ready is high only while the sequencer is idle
// add: scan from the first entry, merge in place on a matching day, else shift
// the tail up by one, place the new entry and hand off; the single read port sets the pace
// read: one memory read, then hand off; clear, rejects and bad index hand off directly
// a finished result waits in the output register while the next request
// is taken; the table memory needs no clearing after reset
module sorted_day_aggregate_table_top #(
    parameter int unsigned TABLE_DEPTH = sdat_pkg::TABLE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    sdat_req_if.sink       req,
    sdat_rsp_if.source     rsp,
    sdat_cfg_if.sink       cfg
);

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_PLACE,
        S_READ,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       held_reg, held_next;
    logic [CW-1:0]       pos_reg, pos_next;
    logic [CW-1:0]       sh_reg, sh_next;
    logic [31:0]         day_reg, day_next;
    logic [15:0]         mins_reg, mins_next;
    logic [15:0]         pages_reg, pages_next;
    sdat_pkg::result_t   res_reg, res_next;
    sdat_pkg::result_t   out_reg, out_next;
    logic                ovalid_reg, ovalid_next;

    logic [31:0]         min_day_reg, min_day_next;
    logic [31:0]         max_day_reg, max_day_next;
    logic [15:0]         max_minutes_reg, max_minutes_next;
    logic                filter_enable_reg, filter_enable_next;
    logic [31:0]         filter_hash_reg, filter_hash_next;

    sdat_pkg::entry_t    mem [TABLE_DEPTH];
    sdat_pkg::entry_t    rd_data_reg;
    logic [AW-1:0]       raddr;
    logic                we;
    logic [AW-1:0]       waddr;
    sdat_pkg::entry_t    wdata;

    logic                accept;
    logic                not_found;
    logic [8:0]          cnt9;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign cnt9      = 9'(held_reg);

    assign rsp.valid          = ovalid_reg;
    assign rsp.status         = out_reg.status;
    assign rsp.entry_day      = out_reg.entry.day;
    assign rsp.entry_minutes  = out_reg.entry.minutes;
    assign rsp.entry_pages    = out_reg.entry.pages;
    assign rsp.entry_sessions = out_reg.entry.sessions;
    assign rsp.entry_count    = out_reg.count;

    // entry store with one write and one read port, read data registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    always_comb
    begin
        state_next         = state_reg;
        held_next          = held_reg;
        pos_next           = pos_reg;
        sh_next            = sh_reg;
        day_next           = day_reg;
        mins_next          = mins_reg;
        pages_next         = pages_reg;
        res_next           = res_reg;
        out_next           = out_reg;
        ovalid_next        = ovalid_reg;
        min_day_next       = min_day_reg;
        max_day_next       = max_day_reg;
        max_minutes_next   = max_minutes_reg;
        filter_enable_next = filter_enable_reg;
        filter_hash_next   = filter_hash_reg;
        raddr              = AW'(pos_reg);
        we                 = 1'b0;
        waddr              = AW'(pos_reg);
        wdata              = rd_data_reg;
        not_found          = 1'b0;

        if (cfg.valid)
        begin
            case (cfg.index)
                sdat_pkg::CFG_MIN_DAY:       min_day_next       = cfg.data;
                sdat_pkg::CFG_MAX_DAY:       max_day_next       = cfg.data;
                sdat_pkg::CFG_MAX_MINUTES:   max_minutes_next   = cfg.data[15:0];
                sdat_pkg::CFG_FILTER_ENABLE: filter_enable_next = cfg.data[0];
                sdat_pkg::CFG_FILTER_HASH:   filter_hash_next   = cfg.data;
                default: ;
            endcase
        end

        if (rsp.ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    day_next   = req.rec_day;
                    mins_next  = req.rec_minutes;
                    pages_next = req.rec_pages;
                    pos_next   = '0;
                    raddr      = '0;
                    res_next   = '0;
                    res_next.count = cnt9;
                    state_next = S_DONE;
                    case (req.op)
                        sdat_pkg::OP_CLEAR:
                        begin
                            held_next       = '0;
                            res_next.status = sdat_pkg::ST_CLEARED;
                            res_next.count  = '0;
                        end
                        sdat_pkg::OP_ADD:
                        begin
                            if (req.rec_day < min_day_reg || req.rec_day > max_day_reg ||
                                req.rec_minutes > max_minutes_reg)
                            begin
                                res_next.status = sdat_pkg::ST_IMPLAUSIBLE;
                            end
                            else if (filter_enable_reg && req.rec_hash != filter_hash_reg)
                            begin
                                res_next.status = sdat_pkg::ST_FILTERED;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        sdat_pkg::OP_READ:
                        begin
                            if (32'(req.read_index) < 32'(held_reg))
                            begin
                                raddr      = AW'(req.read_index);
                                state_next = S_READ;
                            end
                            else
                            begin
                                res_next.status = sdat_pkg::ST_BADINDEX;
                            end
                        end
                        default:
                        begin
                            res_next.status = sdat_pkg::ST_BADINDEX;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // rd_data_reg holds the entry at pos_reg
                if (pos_reg == held_reg)
                begin
                    not_found = 1'b1;
                end
                else if (rd_data_reg.day < day_reg)
                begin
                    pos_next = pos_reg + 1'b1;
                    raddr    = AW'(pos_reg + 1'b1);
                end
                else if (rd_data_reg.day == day_reg)
                begin
                    we                   = 1'b1;
                    waddr                = AW'(pos_reg);
                    wdata.day            = rd_data_reg.day;
                    wdata.minutes        = sdat_pkg::sat_add16(rd_data_reg.minutes, mins_reg);
                    wdata.pages          = sdat_pkg::sat_add16(rd_data_reg.pages, pages_reg);
                    wdata.sessions       = sdat_pkg::sat_add16(rd_data_reg.sessions, 16'd1);
                    res_next.status      = sdat_pkg::ST_MERGED;
                    res_next.entry       = wdata;
                    res_next.count       = cnt9;
                    state_next           = S_DONE;
                end
                else
                begin
                    not_found = 1'b1;
                end

                if (not_found)
                begin
                    if (held_reg == FULL_COUNT)
                    begin
                        res_next.status = sdat_pkg::ST_FULL;
                        state_next      = S_DONE;
                    end
                    else if (held_reg == pos_reg)
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        // start moving the tail up by one, last entry first
                        raddr      = AW'(held_reg - 1'b1);
                        sh_next    = held_reg;
                        state_next = S_SHIFT;
                    end
                end
            end

            S_SHIFT:
            begin
                we      = 1'b1;
                waddr   = AW'(sh_reg);
                wdata   = rd_data_reg;
                sh_next = sh_reg - 1'b1;
                raddr   = AW'(sh_reg - CW'(2));
                if (sh_reg - 1'b1 == pos_reg)
                begin
                    state_next = S_PLACE;
                end
            end

            S_PLACE:
            begin
                we                    = 1'b1;
                waddr                 = AW'(pos_reg);
                wdata.day             = day_reg;
                wdata.minutes         = mins_reg;
                wdata.pages           = pages_reg;
                wdata.sessions        = 16'd1;
                held_next             = held_reg + 1'b1;
                res_next.status       = sdat_pkg::ST_INSERTED;
                res_next.entry        = wdata;
                res_next.count        = 9'(held_reg + 1'b1);
                state_next            = S_DONE;
            end

            S_READ:
            begin
                res_next.status = sdat_pkg::ST_MERGED;
                res_next.entry  = rd_data_reg;
                res_next.count  = cnt9;
                state_next      = S_DONE;
            end

            S_DONE:
            begin
                if (!ovalid_reg || rsp.ready)
                begin
                    out_next    = res_reg;
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            held_reg          <= '0;
            ovalid_reg        <= 1'b0;
            min_day_reg       <= sdat_pkg::MIN_DAY_RST;
            max_day_reg       <= sdat_pkg::MAX_DAY_RST;
            max_minutes_reg   <= sdat_pkg::MAX_MINUTES_RST;
            filter_enable_reg <= 1'b0;
            filter_hash_reg   <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            held_reg          <= held_next;
            ovalid_reg        <= ovalid_next;
            min_day_reg       <= min_day_next;
            max_day_reg       <= max_day_next;
            max_minutes_reg   <= max_minutes_next;
            filter_enable_reg <= filter_enable_next;
            filter_hash_reg   <= filter_hash_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        sh_reg    <= sh_next;
        day_reg   <= day_next;
        mins_reg  <= mins_next;
        pages_reg <= pages_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

endmodule

>>> hw/rtl/sdat_checker.sv
// port-level checks for the sorted day aggregate table
// depends on sdat_pkg; bound to sorted_day_aggregate_table_top below
module sdat_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [2:0]  rsp_status,
    input logic [31:0] rsp_entry_day,
    input logic [15:0] rsp_entry_minutes,
    input logic [15:0] rsp_entry_pages,
    input logic [15:0] rsp_entry_sessions,
    input logic [8:0]  rsp_entry_count
);

    logic rejected;
    logic stored;

    assign rejected = rsp_status == sdat_pkg::ST_IMPLAUSIBLE ||
                      rsp_status == sdat_pkg::ST_FILTERED ||
                      rsp_status == sdat_pkg::ST_FULL ||
                      rsp_status == sdat_pkg::ST_BADINDEX ||
                      rsp_status == sdat_pkg::ST_CLEARED;
    assign stored   = rsp_status == sdat_pkg::ST_MERGED ||
                      rsp_status == sdat_pkg::ST_INSERTED;

    // a clear leaves the table empty
    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == sdat_pkg::ST_CLEARED |-> rsp_entry_count == 9'd0)
        else $error("cleared result with nonzero count");

    // results that touch no entry carry zero entry fields
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rejected |-> rsp_entry_day == 32'd0 && rsp_entry_minutes == 16'd0 &&
            rsp_entry_pages == 16'd0 && rsp_entry_sessions == 16'd0)
        else $error("rejected result with entry data");

    // a merged, inserted or read entry exists and holds at least one session
    a_stored_entry: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && stored |-> rsp_entry_count != 9'd0 && rsp_entry_sessions != 16'd0)
        else $error("stored entry missing or without sessions");

    // a stalled result stays valid and keeps its status, day and count
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
            $stable(rsp_entry_day) && $stable(rsp_entry_count))
        else $error("stalled result changed");

endmodule

bind sorted_day_aggregate_table_top sdat_checker u_sdat_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_status         (rsp.status),
    .rsp_entry_day      (rsp.entry_day),
    .rsp_entry_minutes  (rsp.entry_minutes),
    .rsp_entry_pages    (rsp.entry_pages),
    .rsp_entry_sessions (rsp.entry_sessions),
    .rsp_entry_count    (rsp.entry_count)
);

>>> sim/sorted_day_aggregate_table_top_tb.sv
// self-checking testbench for sorted_day_aggregate_table_top: directed table, table fill,
// randomized phases and a short same-day merge run, checked against an internal predictor or fixed expected results
// depends on sdat_pkg, sdat_req_if, sdat_rsp_if, sdat_cfg_if and the top level
module sorted_day_aggregate_table_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DEPTH      = sdat_pkg::TABLE_DEPTH_DEF;
    localparam int unsigned CLK_PERIOD = 10;
    localparam int unsigned LONG_HOLD  = 300;
    localparam int unsigned SOAK_ADDS  = 30;
    localparam logic [1:0]  OP_UNUSED  = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] day;
        logic [15:0] minutes;
        logic [15:0] pages;
        logic [31:0] hash;
        logic [7:0]  index;
    } req_item_t;

    typedef struct {
        bit                  is_cfg;
        sdat_pkg::cfg_idx_t  cfg_index;
        logic [31:0]         cfg_data;
        req_item_t           item;
        bit                  has_exp;
        sdat_pkg::result_t   exp;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    sdat_req_if req();
    sdat_rsp_if rsp();
    sdat_cfg_if cfg();

    sorted_day_aggregate_table_top #(
        .TABLE_DEPTH(DEPTH)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // predictor copy of the aggregate table and its registers
    logic [31:0] day_tab [DEPTH];
    logic [15:0] min_tab [DEPTH];
    logic [15:0] page_tab [DEPTH];
    logic [15:0] sess_tab [DEPTH];
    int unsigned held = 0;

    logic [31:0] lim_min_day     = sdat_pkg::MIN_DAY_RST;
    logic [31:0] lim_max_day     = sdat_pkg::MAX_DAY_RST;
    logic [15:0] lim_max_minutes = sdat_pkg::MAX_MINUTES_RST;
    logic        flt_en          = 1'b0;
    logic [31:0] flt_hash        = '0;

    sdat_pkg::result_t pending_results[$];
    int unsigned n_errors = 0;
    bit quiet = 1'b0;
    bit hold_req = 1'b0;

    function automatic logic [15:0] clip16(logic [15:0] a, logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    function automatic sdat_pkg::entry_t entry_at(int unsigned pos);
        sdat_pkg::entry_t e;
        e.day      = day_tab[pos];
        e.minutes  = min_tab[pos];
        e.pages    = page_tab[pos];
        e.sessions = sess_tab[pos];
        return e;
    endfunction

    // applies one request to the predicted table and returns the result it should give
    function automatic sdat_pkg::result_t table_update(req_item_t it);
        sdat_pkg::result_t r;
        int unsigned pos;
        r = '0;
        case (it.op)
            sdat_pkg::OP_CLEAR:
            begin
                held = 0;
                r.status = sdat_pkg::ST_CLEARED;
            end
            sdat_pkg::OP_READ:
            begin
                if (it.index < held)
                begin
                    r.status = sdat_pkg::ST_MERGED;
                    r.entry  = entry_at(it.index);
                end
                else
                begin
                    r.status = sdat_pkg::ST_BADINDEX;
                end
            end
            sdat_pkg::OP_ADD:
            begin
                if (it.day < lim_min_day || it.day > lim_max_day
                        || it.minutes > lim_max_minutes)
                begin
                    r.status = sdat_pkg::ST_IMPLAUSIBLE;
                end
                else if (flt_en && it.hash != flt_hash)
                begin
                    r.status = sdat_pkg::ST_FILTERED;
                end
                else
                begin
                    pos = 0;
                    while (pos < held && day_tab[pos] < it.day)
                        pos++;
                    if (pos < held && day_tab[pos] == it.day)
                    begin
                        min_tab[pos]  = clip16(min_tab[pos], it.minutes);
                        page_tab[pos] = clip16(page_tab[pos], it.pages);
                        sess_tab[pos] = clip16(sess_tab[pos], 16'd1);
                        r.status = sdat_pkg::ST_MERGED;
                        r.entry  = entry_at(pos);
                    end
                    else if (held >= DEPTH)
                    begin
                        r.status = sdat_pkg::ST_FULL;
                    end
                    else
                    begin
                        for (int unsigned k = held; k > pos; k--)
                        begin
                            day_tab[k]  = day_tab[k - 1];
                            min_tab[k]  = min_tab[k - 1];
                            page_tab[k] = page_tab[k - 1];
                            sess_tab[k] = sess_tab[k - 1];
                        end
                        day_tab[pos]  = it.day;
                        min_tab[pos]  = it.minutes;
                        page_tab[pos] = it.pages;
                        sess_tab[pos] = 16'd1;
                        held++;
                        r.status = sdat_pkg::ST_INSERTED;
                        r.entry  = entry_at(pos);
                    end
                end
            end
            default: r.status = sdat_pkg::ST_BADINDEX;
        endcase
        r.count = held[8:0];
        return r;
    endfunction

    function automatic sdat_pkg::result_t res(sdat_pkg::status_t st, logic [31:0] day,
                                              logic [15:0] m, logic [15:0] p,
                                              logic [15:0] s, logic [8:0] cnt);
        sdat_pkg::result_t r;
        r.status         = st;
        r.entry.day      = day;
        r.entry.minutes  = m;
        r.entry.pages    = p;
        r.entry.sessions = s;
        r.count          = cnt;
        return r;
    endfunction

    function automatic stim_row_t rq(logic [1:0] op, logic [31:0] day, logic [15:0] mins,
                                     logic [15:0] pages, logic [31:0] hash, logic [7:0] idx);
        stim_row_t r;
        r.is_cfg       = 1'b0;
        r.cfg_index    = sdat_pkg::CFG_MIN_DAY;
        r.cfg_data     = '0;
        r.has_exp      = 1'b0;
        r.exp          = '0;
        r.item.op      = op;
        r.item.day     = day;
        r.item.minutes = mins;
        r.item.pages   = pages;
        r.item.hash    = hash;
        r.item.index   = idx;
        return r;
    endfunction

    function automatic stim_row_t chk(stim_row_t r, sdat_pkg::result_t e);
        r.has_exp = 1'b1;
        r.exp     = e;
        return r;
    endfunction

    function automatic stim_row_t reg_row(sdat_pkg::cfg_idx_t idx, logic [31:0] data);
        stim_row_t r;
        r = rq(sdat_pkg::OP_CLEAR, '0, '0, '0, '0, '0);
        r.is_cfg    = 1'b1;
        r.cfg_index = idx;
        r.cfg_data  = data;
        return r;
    endfunction

    // mostly well-formed adds around a day pool, with reads, clears and noise mixed in
    function automatic req_item_t random_item(logic [31:0] pool_base, int unsigned pool_span);
        req_item_t it;
        int unsigned pick;
        it.op      = sdat_pkg::OP_ADD;
        it.day     = pool_base + $urandom_range(0, pool_span);
        it.minutes = 16'($urandom_range(0, lim_max_minutes));
        it.pages   = 16'($urandom);
        it.hash    = (flt_en && $urandom_range(0, 9) != 0) ? flt_hash : $urandom;
        it.index   = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 2)
        begin
            it.op = sdat_pkg::OP_CLEAR;
        end
        else if (pick < 5)
        begin
            it.op = OP_UNUSED;
        end
        else if (pick < 30)
        begin
            it.op = sdat_pkg::OP_READ;
            if (held > 0 && $urandom_range(0, 4) != 0)
                it.index = 8'($urandom_range(0, held - 1));
        end
        else if (pick < 45)
        begin
            it.hash = $urandom;
            case ($urandom_range(0, 3))
                0: it.day = $urandom;
                1: it.day = lim_min_day - 1;
                2: it.day = lim_max_day + 1;
                default: it.minutes = 16'($urandom);
            endcase
        end
        return it;
    endfunction

    task automatic report_field(string name, logic [31:0] exp, logic [31:0] act);
        if (exp !== act)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, exp, act);
            n_errors++;
        end
    endtask

    task automatic check_result();
        sdat_pkg::result_t e;
        if (pending_results.size() == 0)
        begin
            $error("unexpected result: status %0d day %0h count %0d",
                   rsp.status, rsp.entry_day, rsp.entry_count);
            n_errors++;
        end
        else
        begin
            e = pending_results.pop_front();
            report_field("status", e.status, rsp.status);
            report_field("entry_day", e.entry.day, rsp.entry_day);
            report_field("entry_minutes", e.entry.minutes, rsp.entry_minutes);
            report_field("entry_pages", e.entry.pages, rsp.entry_pages);
            report_field("entry_sessions", e.entry.sessions, rsp.entry_sessions);
            report_field("entry_count", e.count, rsp.entry_count);
        end
    endtask

    // offers one request; valid is left high so a back-to-back request needs no new edge
    task automatic send_req(req_item_t it, bit use_exp, sdat_pkg::result_t exp);
        int unsigned gap;
        sdat_pkg::result_t got;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid       <= 1'b1;
        req.op          <= it.op;
        req.rec_day     <= it.day;
        req.rec_minutes <= it.minutes;
        req.rec_pages   <= it.pages;
        req.rec_hash    <= it.hash;
        req.read_index  <= it.index;
        do @(posedge clk); while (!req.ready);
        got = table_update(it);
        pending_results.push_back(use_exp ? exp : got);
    endtask

    task automatic drain_results();
        req.valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    task automatic write_reg(sdat_pkg::cfg_idx_t idx, logic [31:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do @(posedge clk); while (!cfg.ready);
        case (idx)
            sdat_pkg::CFG_MIN_DAY:       lim_min_day = data;
            sdat_pkg::CFG_MAX_DAY:       lim_max_day = data;
            sdat_pkg::CFG_MAX_MINUTES:   lim_max_minutes = data[15:0];
            sdat_pkg::CFG_FILTER_ENABLE: flt_en = data[0];
            sdat_pkg::CFG_FILTER_HASH:   flt_hash = data;
            default: ;
        endcase
    endtask

    task automatic apply_settings(logic [31:0] lo, logic [31:0] hi, logic [15:0] mins,
                                  logic fen, logic [31:0] fhash);
        drain_results();
        write_reg(sdat_pkg::CFG_MIN_DAY, lo);
        write_reg(sdat_pkg::CFG_MAX_DAY, hi);
        write_reg(sdat_pkg::CFG_MAX_MINUTES, {16'd0, mins});
        write_reg(sdat_pkg::CFG_FILTER_ENABLE, {31'd0, fen});
        write_reg(sdat_pkg::CFG_FILTER_HASH, fhash);
        cfg.valid <= 1'b0;
    endtask

    initial
    begin : rsp_sink
        int unsigned stall_left;
        bit hold_done;
        stall_left = 0;
        hold_done  = 1'b0;
        rsp.ready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp.valid && rsp.ready)
                check_result();
            // one long hold-off so the block backs up and stalls its request side
            if (hold_req && !hold_done)
            begin
                hold_done  = 1'b1;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(0, 7);
                rsp.ready <= 1'b0;
            end
            else
            begin
                rsp.ready <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        stim_row_t   rows[$];
        req_item_t   it;
        logic [31:0] fill_days [DEPTH];
        logic [31:0] tmp;
        logic [31:0] pool_base;
        int unsigned pool_span;
        int unsigned n_items;
        int unsigned j;

        req.valid       = 1'b0;
        req.op          = sdat_pkg::OP_CLEAR;
        req.rec_day     = '0;
        req.rec_minutes = '0;
        req.rec_pages   = '0;
        req.rec_hash    = '0;
        req.read_index  = '0;
        cfg.valid       = 1'b0;
        cfg.index       = sdat_pkg::CFG_MIN_DAY;
        cfg.data        = '0;

        // reset window, edges of the plausible range and the implausible, filtered and bad-index rejects
        rows.push_back(chk(rq(sdat_pkg::OP_READ, 0, 0, 0, 0, 0),
                           res(sdat_pkg::ST_BADINDEX, 0, 0, 0, 0, 0)));
        rows.push_back(chk(rq(sdat_pkg::OP_CLEAR, 0, 0, 0, 0, 0),
                           res(sdat_pkg::ST_CLEARED, 0, 0, 0, 0, 0)));
        rows.push_back(chk(rq(sdat_pkg::OP_ADD, 18262, 0, 0, 0, 0),
                           res(sdat_pkg::ST_INSERTED, 18262, 0, 0, 1, 1)));
        rows.push_back(chk(rq(sdat_pkg::OP_ADD, 47481, 1440, 16'hFFFF, 32'hFFFF_FFFF, 0),
                           res(sdat_pkg::ST_INSERTED, 47481, 1440, 16'hFFFF, 1, 2)));
        rows.push_back(chk(rq(sdat_pkg::OP_ADD, 18261, 10, 10, 0, 0),
                           res(sdat_pkg::ST_IMPLAUSIBLE, 0, 0, 0, 0, 2)));
        rows.push_back(chk(rq(sdat_pkg::OP_ADD, 47482, 10, 10, 0, 0),
                           res(sdat_pkg::ST_IMPLAUSIBLE, 0, 0, 0, 0, 2)));
        rows.push_back(chk(rq(sdat_pkg::OP_ADD, 20000, 1441, 10, 0, 0),
                           res(sdat_pkg::ST_IMPLAUSIBLE, 0, 0, 0, 0, 2)));
        rows.push_back(rq(sdat_pkg::OP_ADD, 30000, 100, 7, 0, 0));
        rows.push_back(rq(sdat_pkg::OP_ADD, 30000, 1440, 16'hFFFF, 0, 0));
        rows.push_back(rq(sdat_pkg::OP_READ, 0, 0, 0, 0, 0));
        rows.push_back(rq(sdat_pkg::OP_READ, 0, 0, 0, 0, 2));
        rows.push_back(chk(rq(sdat_pkg::OP_READ, 0, 0, 0, 0, 3),
                           res(sdat_pkg::ST_BADINDEX, 0, 0, 0, 0, 3)));
        rows.push_back(chk(rq(sdat_pkg::OP_READ, 0, 0, 0, 0, 8'hFF),
                           res(sdat_pkg::ST_BADINDEX, 0, 0, 0, 0, 3)));
        rows.push_back(chk(rq(OP_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                              8'hFF), res(sdat_pkg::ST_BADINDEX, 0, 0, 0, 0, 3)));
        rows.push_back(reg_row(sdat_pkg::CFG_FILTER_HASH, 32'hDEAD_BEEF));
        rows.push_back(reg_row(sdat_pkg::CFG_FILTER_ENABLE, 1));
        rows.push_back(chk(rq(sdat_pkg::OP_ADD, 20000, 5, 5, 0, 0),
                           res(sdat_pkg::ST_FILTERED, 0, 0, 0, 0, 3)));
        rows.push_back(rq(sdat_pkg::OP_ADD, 20000, 5, 5, 32'hDEAD_BEEF, 0));
        rows.push_back(chk(rq(sdat_pkg::OP_ADD, 20000, 5, 5, 32'hDEAD_BEF0, 0),
                           res(sdat_pkg::ST_FILTERED, 0, 0, 0, 0, 4)));
        // day check wins over the hash check
        rows.push_back(chk(rq(sdat_pkg::OP_ADD, 18000, 5, 5, 0, 0),
                           res(sdat_pkg::ST_IMPLAUSIBLE, 0, 0, 0, 0, 4)));
        rows.push_back(reg_row(sdat_pkg::CFG_MIN_DAY, 0));
        rows.push_back(reg_row(sdat_pkg::CFG_MAX_DAY, 32'hFFFF_FFFF));
        rows.push_back(reg_row(sdat_pkg::CFG_MAX_MINUTES, 32'h0000_FFFF));
        rows.push_back(reg_row(sdat_pkg::CFG_FILTER_ENABLE, 0));
        rows.push_back(rq(sdat_pkg::OP_ADD, 0, 16'hFFFF, 16'hFFFF, 0, 0));
        rows.push_back(rq(sdat_pkg::OP_ADD, 32'hFFFF_FFFF, 16'hFFFF, 1, 0, 0));
        rows.push_back(chk(rq(sdat_pkg::OP_ADD, 0, 1, 1, 0, 0),
                           res(sdat_pkg::ST_MERGED, 0, 16'hFFFF, 16'hFFFF, 2, 6)));
        rows.push_back(chk(rq(sdat_pkg::OP_CLEAR, 0, 0, 0, 0, 0),
                           res(sdat_pkg::ST_CLEARED, 0, 0, 0, 0, 0)));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < rows.size(); i++)
        begin
            if (rows[i].is_cfg)
            begin
                if (i == 0 || !rows[i - 1].is_cfg)
                    drain_results();
                write_reg(rows[i].cfg_index, rows[i].cfg_data);
                if (i == rows.size() - 1 || !rows[i + 1].is_cfg)
                    cfg.valid <= 1'b0;
            end
            else
            begin
                send_req(rows[i].item, rows[i].has_exp, rows[i].exp);
            end
        end

        // fill every slot in shuffled order, then hit the full table
        for (int i = 0; i < DEPTH; i++)
            fill_days[i] = i * 1000 + 7;
        for (int i = DEPTH - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp          = fill_days[i];
            fill_days[i] = fill_days[j];
            fill_days[j] = tmp;
        end
        it = '0;
        it.op = sdat_pkg::OP_CLEAR;
        send_req(it, 1'b0, '0);
        for (int i = 0; i < DEPTH; i++)
        begin
            it.op      = sdat_pkg::OP_ADD;
            it.day     = fill_days[i];
            it.minutes = 16'($urandom);
            it.pages   = 16'($urandom);
            it.hash    = $urandom;
            send_req(it, 1'b0, '0);
        end
        it.day = 32'd500;
        send_req(it, 1'b0, '0);
        it.day = fill_days[0];
        send_req(it, 1'b0, '0);
        it.op    = sdat_pkg::OP_READ;
        it.index = 8'hFF;
        send_req(it, 1'b0, '0);
        it.index = 8'h00;
        send_req(it, 1'b0, '0);

        // randomized phases, each under its own register setting
        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0:
                begin
                    apply_settings(sdat_pkg::MIN_DAY_RST, sdat_pkg::MAX_DAY_RST,
                                   sdat_pkg::MAX_MINUTES_RST, 1'b0, $urandom);
                    pool_base = $urandom_range(sdat_pkg::MIN_DAY_RST,
                                               sdat_pkg::MAX_DAY_RST - 63);
                    pool_span = 63;
                    n_items   = 40;
                    hold_req  = 1'b1;
                end
                1:
                begin
                    tmp = $urandom_range(0, 32'h7FFF_FFFF);
                    apply_settings(tmp, tmp + 40, 16'($urandom_range(1, 200)), 1'b1, $urandom);
                    pool_base = tmp - 4;
                    pool_span = 48;
                    n_items   = 40;
                end
                2:
                begin
                    apply_settings(0, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 32'hFFFF_FFFF);
                    pool_base = 32'hFFFF_FFC0;
                    pool_span = 127;
                    n_items   = 40;
                end
                3:
                begin
                    // empty window: min above max
                    apply_settings(5, 4, 0, 1'b1, 0);
                    pool_base = 0;
                    pool_span = 15;
                    n_items   = 20;
                end
                default:
                begin
                    apply_settings(1000, 1063, 0, 1'b1, 32'hFFFF_FFFF);
                    pool_base = 1000;
                    pool_span = 63;
                    n_items   = 40;
                end
            endcase
            for (int n = 0; n < n_items; n++)
                send_req(random_item(pool_base, pool_span), 1'b0, '0);
        end

        // last stretch with no idling: one day merged until minutes and pages saturate
        apply_settings(0, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 0);
        quiet = 1'b1;
        it = '0;
        it.op = sdat_pkg::OP_CLEAR;
        send_req(it, 1'b0, '0);
        for (int n = 0; n < SOAK_ADDS; n++)
        begin
            it.op      = sdat_pkg::OP_ADD;
            it.day     = 32'h8000_0001;
            it.minutes = 16'($urandom);
            it.pages   = 16'($urandom);
            it.hash    = $urandom;
            send_req(it, 1'b0, '0);
        end
        it.op    = sdat_pkg::OP_READ;
        it.index = 0;
        send_req(it, 1'b0, '0);

        req.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (n_errors == 0)
            $display("** sorted_day_aggregate_table_top: PASSED **");
        else
            $display("** sorted_day_aggregate_table_top: FAILED **");
        $finish;
    end

    initial
    begin : watchdog
        #(30_000_000);
        $display("** sorted_day_aggregate_table_top: FAILED **");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/sdat_pkg.sv
hw/rtl/sdat_req_if.sv
hw/rtl/sdat_rsp_if.sv
hw/rtl/sdat_cfg_if.sv
hw/rtl/sorted_day_aggregate_table_top.sv
hw/rtl/sdat_checker.sv
sim/sorted_day_aggregate_table_top_tb.sv
